// ===== sv/fct_pkg.sv =====
// Shared types, constants and helpers for the frustum cull tester.
package fct_pkg;

  // Fixed-point format of coordinates and matrix elements
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Configuration register file: eight 64-bit words, two elements each
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int HALF_W    = 32;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int NUM_ELEMS = 2 * NUM_REGS;

  // Plane layout: each plane is column 3 plus or minus one other column
  localparam int NUM_PLANES = 6;
  localparam int NUM_COEFS  = 4;
  localparam int COL3_BASE  = 12;

  // Arithmetic widths, sized so that every sum is exact
  localparam int COEF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * COORD_WIDTH + 1;
  localparam int ACC_W  = (2 * COORD_WIDTH > COORD_WIDTH + FRAC_BITS) ?
                          2 * COORD_WIDTH + 3 : COORD_WIDTH + FRAC_BITS + 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic        [COORD_WIDTH-2:0] rad_t;

  // Test kinds
  localparam logic [1:0] CMD_POINT  = 2'd0;
  localparam logic [1:0] CMD_SPHERE = 2'd1;
  localparam logic [1:0] CMD_BOX    = 2'd2;

  // One test word as it travels down the chain of plane cells
  typedef struct packed {
    logic [1:0]   command;
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    rad_t         radius;
    logic         visible;
  } item_t;

  // Plane coefficient: column 3 element plus or minus the other column's element
  function automatic coef_t plane_coef(coord_t c3, coord_t ck, logic sub);
    coef_t a;
    coef_t b;
    a = coef_t'(c3);
    b = coef_t'(ck);
    return sub ? coef_t'(a - b) : coef_t'(a + b);
  endfunction

endpackage

// ===== sv/frustum_cull_tester.sv =====
// Frustum cull tester: six plane cells in a row, one per Gribb-Hartmann plane.
// Each plane cell holds two register stages.
// Throughput: one test word per cycle while out_stall is low; each cell has its own multipliers.
// Output stalls back up stage by stage, so bubbles are squeezed out before input stalls.
// Reset clears the matrix registers to zero and empties the pipeline.
module frustum_cull_tester (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fct_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [fct_pkg::REG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic signed [31:0]                first_x,
  input  logic signed [31:0]                first_y,
  input  logic signed [31:0]                first_z,
  input  logic signed [31:0]                max_x,
  input  logic signed [31:0]                max_y,
  input  logic signed [31:0]                max_z,
  input  logic [30:0]                       radius,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              visible
);

  logic [fct_pkg::REG_W-1:0] vp [fct_pkg::NUM_REGS];
  fct_pkg::coord_t           elem [fct_pkg::NUM_ELEMS];
  fct_pkg::coef_t [fct_pkg::NUM_COEFS-1:0] coef [fct_pkg::NUM_PLANES];

  fct_pkg::item_t link       [fct_pkg::NUM_PLANES+1];
  logic           link_valid [fct_pkg::NUM_PLANES+1];
  logic           link_ready [fct_pkg::NUM_PLANES+1];

  // Matrix register file, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fct_pkg::NUM_REGS; i++) begin
        vp[i] <= '0;
      end
    end else if (cfg_valid) begin
      vp[cfg_index] <= cfg_data;
    end
  end

  // Unpack elements: low half is the even element, high half the odd one
  always_comb begin
    for (int i = 0; i < fct_pkg::NUM_REGS; i++) begin
      elem[2*i]   = fct_pkg::coord_t'(vp[i][fct_pkg::COORD_WIDTH-1:0]);
      elem[2*i+1] = fct_pkg::coord_t'(
                      vp[i][fct_pkg::HALF_W+fct_pkg::COORD_WIDTH-1:fct_pkg::HALF_W]);
    end
  end

  // Planes: left/right use column 0, bottom/top column 1, near/far column 2
  for (genvar p = 0; p < fct_pkg::NUM_PLANES; p++) begin : g_plane
    for (genvar k = 0; k < fct_pkg::NUM_COEFS; k++) begin : g_coef
      assign coef[p][k] = fct_pkg::plane_coef(elem[fct_pkg::COL3_BASE + k],
                                              elem[(p >> 1) * fct_pkg::NUM_COEFS + k],
                                              1'(p & 1));
    end
  end

  // Input word; unused command code starts out rejected
  always_comb begin
    link[0].command = command;
    link[0].lo[0]   = fct_pkg::coord_t'(first_x[fct_pkg::COORD_WIDTH-1:0]);
    link[0].lo[1]   = fct_pkg::coord_t'(first_y[fct_pkg::COORD_WIDTH-1:0]);
    link[0].lo[2]   = fct_pkg::coord_t'(first_z[fct_pkg::COORD_WIDTH-1:0]);
    link[0].hi[0]   = fct_pkg::coord_t'(max_x[fct_pkg::COORD_WIDTH-1:0]);
    link[0].hi[1]   = fct_pkg::coord_t'(max_y[fct_pkg::COORD_WIDTH-1:0]);
    link[0].hi[2]   = fct_pkg::coord_t'(max_z[fct_pkg::COORD_WIDTH-1:0]);
    link[0].radius  = radius[fct_pkg::COORD_WIDTH-2:0];
    link[0].visible = (command == fct_pkg::CMD_POINT) ||
                      (command == fct_pkg::CMD_SPHERE) ||
                      (command == fct_pkg::CMD_BOX);
  end

  assign link_valid[0] = in_valid;
  assign in_stall      = !link_ready[0];

  // Chain of plane cells
  for (genvar p = 0; p < fct_pkg::NUM_PLANES; p++) begin : g_cell
    fct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .coef_in   (coef[p]),
      .in_valid  (link_valid[p]),
      .in_ready  (link_ready[p]),
      .in_item   (link[p]),
      .out_valid (link_valid[p+1]),
      .out_ready (link_ready[p+1]),
      .out_item  (link[p+1])
    );
  end

  // Last cell's second stage is the output register
  assign link_ready[fct_pkg::NUM_PLANES] = !out_stall;
  assign out_valid = link_valid[fct_pkg::NUM_PLANES];
  assign visible   = link[fct_pkg::NUM_PLANES].visible;

endmodule

// ===== sv/fct_cell.sv =====
// One plane cell: multiplies the object against its plane and passes the word on.
module fct_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  fct_pkg::coef_t [fct_pkg::NUM_COEFS-1:0] coef_in,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  fct_pkg::item_t                     in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output fct_pkg::item_t                     out_item
);

  fct_pkg::coef_t [fct_pkg::NUM_COEFS-1:0] coef_r;

  logic            s1_valid;
  fct_pkg::item_t  s1_item;
  fct_pkg::prod_t  s1_prod [3];
  fct_pkg::acc_t   s1_partial;

  logic            s2_valid;
  fct_pkg::item_t  s2_item;
  fct_pkg::item_t  s2_item_next;

  fct_pkg::coord_t vert [3];
  fct_pkg::prod_t  prod_next [3];
  fct_pkg::acc_t   partial_next;
  fct_pkg::acc_t   plane_dist;
  logic            s1_ready;
  logic            s2_ready;

  // Plane coefficients follow the matrix registers
  assign coef_r = coef_in;

  // Stage 1: pick the positive vertex for boxes, then multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (in_item.command == fct_pkg::CMD_BOX && !coef_r[k][fct_pkg::COEF_W-1]) begin
        vert[k] = $signed(in_item.hi[k]);
      end else begin
        vert[k] = $signed(in_item.lo[k]);
      end
      prod_next[k] = fct_pkg::prod_t'($signed(coef_r[k])) * fct_pkg::prod_t'(vert[k]);
    end
    partial_next = fct_pkg::acc_t'($signed(coef_r[3])) <<< fct_pkg::FRAC_BITS;
    if (in_item.command == fct_pkg::CMD_SPHERE) begin
      partial_next = partial_next +
                     (fct_pkg::acc_t'({1'b0, in_item.radius}) <<< fct_pkg::FRAC_BITS);
    end
  end

  // Stage 2: plane distance and sign test
  always_comb begin
    plane_dist = fct_pkg::acc_t'(s1_prod[0]) + fct_pkg::acc_t'(s1_prod[1]) +
                 fct_pkg::acc_t'(s1_prod[2]) + s1_partial;
    s2_item_next         = s1_item;
    s2_item_next.visible = s1_item.visible & ~plane_dist[fct_pkg::ACC_W-1];
  end

  // Each stage moves when empty or when the stage after it moves
  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_item    <= in_item;
      s1_partial <= partial_next;
      for (int k = 0; k < 3; k++) begin
        s1_prod[k] <= prod_next[k];
      end
    end
    if (s1_valid && s2_ready) begin
      s2_item <= s2_item_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_item  = s2_item;

endmodule

// ===== sv/fct_checker.sv =====
// Port-level checks for the frustum cull tester, bound to the top level.
module fct_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [fct_pkg::REG_IDX_W-1:0] cfg_index,
  input logic [fct_pkg::REG_W-1:0]     cfg_data,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    command,
  input logic signed [31:0]            first_x,
  input logic signed [31:0]            first_y,
  input logic signed [31:0]            first_z,
  input logic signed [31:0]            max_x,
  input logic signed [31:0]            max_y,
  input logic signed [31:0]            max_z,
  input logic [30:0]                   radius,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          visible
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present right after reset");

  // With no result waiting the chain has room, so input is never stalled
  a_room_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  // A stalled result holds its value
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(visible))
    else $error("stalled result word changed or dropped");

  // Matrix registers never refuse a write
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind frustum_cull_tester fct_checker u_fct_checker (.*);
